[src/htd_pkg.sv]
// Shared types and constants for the Huffman tree decoder.
package htd_pkg;

    // Fixed field widths of the word channels
    localparam int CMD_W     = 1;
    localparam int INDEX_W   = 8;
    localparam int CHILD_W   = 9;
    localparam int BYTE_W    = 8;
    localparam int SYMBOL_W  = 8;
    localparam int BIT_CNT_W = $clog2(BYTE_W);
    localparam int ENTRY_W   = 2 * CHILD_W;

    // Child value: top bit set means pointer to node, clear means symbol
    localparam int PTR_FLAG_BIT = CHILD_W - 1;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT_POS = BIT_CNT_W'(BYTE_W - 1);

    // Input word commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DATA = 1'b1;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } htd_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic take_load;   // table node write from input word
        logic take_data;   // latch data byte and read the current node
        logic step;        // consume one bit of the latched byte
    } htd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic finished;    // out_length symbols already produced
        logic out_busy;    // result register full and not taken this cycle
        logic last_bit;    // walking the last bit of the byte
        logic finishing;   // this step emits the final symbol
    } htd_status_t;

endpackage

[src/htd_in_if.sv]
// Input word channel: table loads and compressed data bytes.
interface htd_in_if
    import htd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  node_index;
    logic [CHILD_W-1:0]  zero_child;
    logic [CHILD_W-1:0]  one_child;
    logic [BYTE_W-1:0]   data_byte;

    modport source (
        output valid, cmd, node_index, zero_child, one_child, data_byte,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_index, zero_child, one_child, data_byte,
        output ready
    );
endinterface

[src/htd_out_if.sv]
// Output word channel: decoded symbols.
interface htd_out_if
    import htd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;

    modport source (
        output valid, symbol, last,
        input  ready
    );

    modport sink (
        input  valid, symbol, last,
        output ready
    );
endinterface

[src/htd_ctrl.sv]
// Control state machine: accepts input words and sequences the bit walk.
module htd_ctrl
    import htd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [CMD_W-1:0]   in_cmd,
    output logic               in_ready,
    input  htd_status_t        status,
    output htd_cmd_t           cmd
);

    htd_state_t state_reg;
    htd_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // a data byte after finish is taken and dropped
                if (in_valid && in_cmd == CMD_DATA && !status.finished)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!status.out_busy && (status.last_bit || status.finishing))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.take_load  = 1'b0;
        cmd.take_data  = 1'b0;
        cmd.step       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_load = in_valid && in_cmd == CMD_LOAD;
                cmd.take_data = in_valid && in_cmd == CMD_DATA && !status.finished;
            end
            ST_WALK:
            begin
                cmd.step = !status.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/htd_datapath.sv]
// Node table, walk registers, symbol counter and result register.
module htd_datapath
    import htd_pkg::*;
#(
    parameter int NODE_COUNT   = 255,
    parameter int LENGTH_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [LENGTH_WIDTH-1:0] cfg_wdata,
    input  logic [INDEX_W-1:0]      node_index,
    input  logic [CHILD_W-1:0]      zero_child,
    input  logic [CHILD_W-1:0]      one_child,
    input  logic [BYTE_W-1:0]       data_byte,
    input  htd_cmd_t                cmd,
    output htd_status_t             status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SYMBOL_W-1:0]     out_symbol,
    output logic                    out_last
);

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam logic [NODE_W-1:0]  HEAD_NODE  = NODE_W'(NODE_COUNT - 1);
    localparam logic [INDEX_W-1:0] NODE_LIMIT = INDEX_W'(NODE_COUNT);

    // Node table: {zero child, one child}
    logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [LENGTH_WIDTH-1:0] out_length_reg;
    logic [LENGTH_WIDTH-1:0] symbols_done_reg;
    logic [NODE_W-1:0]       current_node_reg;
    logic                    finished_reg;
    logic [BYTE_W-1:0]       byte_reg;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg;
    logic                    out_valid_reg;
    logic [SYMBOL_W-1:0]     out_symbol_reg;
    logic                    out_last_reg;

    logic                    load_ok;
    logic                    restart;
    logic                    wr_en;
    logic                    rd_en;
    logic [NODE_W-1:0]       rd_addr;
    logic                    cur_bit;
    logic [CHILD_W-1:0]      child;
    logic                    leaf;
    logic [NODE_W-1:0]       next_node;
    logic [LENGTH_WIDTH-1:0] target;
    logic [LENGTH_WIDTH-1:0] symbols_next;
    logic                    hits_target;

    // Load and restart decode; out-of-range loads are ignored
    assign load_ok = node_index < NODE_LIMIT;
    assign wr_en   = cmd.take_load && load_ok;
    assign restart = cfg_we || wr_en;

    // Child selection for the current bit
    assign cur_bit = byte_reg[bit_cnt_reg];
    assign child   = cur_bit ? rd_data_reg[CHILD_W-1:0] : rd_data_reg[ENTRY_W-1:CHILD_W];
    assign leaf    = !child[PTR_FLAG_BIT];

    // Next node: head after a leaf or an out-of-range pointer
    always_comb
    begin
        next_node = HEAD_NODE;
        if (!leaf && child[INDEX_W-1:0] < NODE_LIMIT)
        begin
            next_node = child[NODE_W-1:0];
        end
    end

    // Symbol count against target; a zero length acts as one
    assign target       = (out_length_reg == '0) ? LENGTH_WIDTH'(1) : out_length_reg;
    assign symbols_next = symbols_done_reg + LENGTH_WIDTH'(1);
    assign hits_target  = symbols_next == target;

    // Table read: current node on a new byte, else the node just reached
    assign rd_addr = cmd.take_data ? current_node_reg : next_node;
    assign rd_en   = cmd.take_data ||
                     (cmd.step && bit_cnt_reg != LAST_BIT_POS && !(leaf && hits_target));

    // Node table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[node_index[NODE_W-1:0]] <= {zero_child, one_child};
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_length_reg <= LENGTH_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            out_length_reg <= cfg_wdata;
        end
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_node_reg <= HEAD_NODE;
            symbols_done_reg <= '0;
            finished_reg     <= 1'b0;
            bit_cnt_reg      <= '0;
        end
        else
        begin
            if (restart)
            begin
                current_node_reg <= HEAD_NODE;
                symbols_done_reg <= '0;
                finished_reg     <= 1'b0;
            end
            else if (cmd.step)
            begin
                current_node_reg <= next_node;
                if (leaf)
                begin
                    symbols_done_reg <= symbols_next;
                    finished_reg     <= hits_target;
                end
            end
            if (cmd.take_data)
            begin
                bit_cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
            end
        end
    end

    // Latched data byte
    always_ff @(posedge clk)
    begin
        if (cmd.take_data)
        begin
            byte_reg <= data_byte;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && leaf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && leaf)
        begin
            out_symbol_reg <= child[SYMBOL_W-1:0];
            out_last_reg   <= hits_target;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;

    // Status to controller
    assign status.finished  = finished_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;
    assign status.last_bit  = bit_cnt_reg == LAST_BIT_POS;
    assign status.finishing = leaf && hits_target;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.step)
        else $error("step while result register is held");

    // The symbol count never passes its target
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_we && !$past(cfg_we)) |-> symbols_done_reg <= target)
        else $error("symbol count beyond target");

    // The final symbol is flagged last and stops the walk
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && leaf && hits_target && !restart) |=>
            (finished_reg && out_valid_reg && out_last_reg && !cmd.step))
        else $error("final symbol not closed out");

endmodule

[src/huffman_tree_decoder_top.sv]
// Huffman tree decoder top level: channels, configuration port, submodules.
// Load words (cmd 0) write one node of the table. Data words (cmd 1) latch the
// byte and read the current node, then take its bits in turn, each bit waiting
// on the table read of the node the previous bit reached. The walk pauses while
// a decoded symbol waits on the output and stops early on the symbol that
// completes out_length; a data word after that point is accepted and gives no
// symbol. The node table has no reset and needs no clearing pass. The user must
// set out_length through cfg_we/cfg_wdata only while idle, which the block does
// not enforce; any table or length write restarts decoding from the head node.
module huffman_tree_decoder_top
    import htd_pkg::*;
#(
    parameter int NODE_COUNT   = 255,
    parameter int LENGTH_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [LENGTH_WIDTH-1:0] cfg_wdata,
    htd_in_if.sink                  in_word,
    htd_out_if.source               out_word
);

    htd_cmd_t    cmd;
    htd_status_t status;

    // Controller
    htd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_word.valid),
        .in_cmd   (in_word.cmd),
        .in_ready (in_word.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    htd_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .node_index (in_word.node_index),
        .zero_child (in_word.zero_child),
        .one_child  (in_word.one_child),
        .data_byte  (in_word.data_byte),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_word.valid),
        .out_ready  (out_word.ready),
        .out_symbol (out_word.symbol),
        .out_last   (out_word.last)
    );

endmodule
